@@ hw/rtl/brb_pkg.sv @@
// Shared types and constants for the byte ring buffer.
`timescale 1ns / 1ps

package brb_pkg;

    localparam int DEPTH    = 4096;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int CNT_W    = (CNT_BITS > 13) ? CNT_BITS : 13;
    localparam int LEN_W    = 12;
    localparam int BYTE_W   = 8;
    localparam int REP_W    = 12;

    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_READ   = 3'd1,
        OP_SKIP   = 3'd2,
        OP_COMMIT = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_STATUS = 3'd5
    } brb_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } brb_state_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [IDX_W-1:0]  addr;
        logic [BYTE_W-1:0] wdata;
    } brb_mem_req_t;

    typedef struct packed {
        logic ok;
        logic did_read;
    } brb_step_t;

    typedef struct packed {
        logic [REP_W-1:0] readable;
        logic [REP_W-1:0] writeable;
        logic [REP_W-1:0] direct_readable;
        logic [REP_W-1:0] direct_writeable;
    } brb_counts_t;

endpackage

@@ hw/rtl/brb_ram.sv @@
// Single-port synchronous byte store with registered read data.
`timescale 1ns / 1ps

module brb_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W) - 1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/brb_ctrl.sv @@
// Index and transfer bookkeeping, fill counts and store access requests.
`timescale 1ns / 1ps

module brb_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  brb_pkg::brb_op_t          op,
    input  logic                      first,
    input  logic [brb_pkg::LEN_W-1:0] length,
    input  logic [brb_pkg::BYTE_W-1:0] data,
    output brb_pkg::brb_mem_req_t     mem_req,
    output brb_pkg::brb_step_t        step,
    output brb_pkg::brb_counts_t      counts
);
    import brb_pkg::*;

    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic             rej_reg, rej_next;

    logic [CNT_W-1:0] depth_c, rd_c, wr_c, len_c;
    logic [CNT_W-1:0] readable, writeable, dir_rd, dir_wr;
    logic [CNT_W-1:0] room;
    logic             wrap_free;
    logic             is_read;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] by);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - IDX_W){1'b0}}, idx} + {1'b0, by};
        if (s >= (CNT_W + 1)'(DEPTH))
        begin
            s = s - (CNT_W + 1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    assign depth_c   = CNT_W'(DEPTH);
    assign rd_c      = CNT_W'(rd_idx_reg);
    assign wr_c      = CNT_W'(wr_idx_reg);
    assign len_c     = CNT_W'(length);
    assign wrap_free = (wr_idx_reg >= rd_idx_reg);

    always_comb
    begin
        if (wrap_free)
        begin
            readable  = wr_c - rd_c;
            writeable = depth_c - wr_c + rd_c - CNT_W'(1);
            dir_rd    = wr_c - rd_c;
            dir_wr    = depth_c - wr_c - ((rd_idx_reg == '0) ? CNT_W'(1) : CNT_W'(0));
        end
        else
        begin
            readable  = depth_c - rd_c + wr_c;
            writeable = rd_c - wr_c - CNT_W'(1);
            dir_rd    = depth_c - rd_c;
            dir_wr    = rd_c - wr_c - CNT_W'(1);
        end
    end

    assign counts.readable         = readable[REP_W-1:0];
    assign counts.writeable        = writeable[REP_W-1:0];
    assign counts.direct_readable  = dir_rd[REP_W-1:0];
    assign counts.direct_writeable = dir_wr[REP_W-1:0];

    assign is_read = (op == OP_READ);
    assign room    = is_read ? readable : writeable;

    always_comb
    begin
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        left_next     = left_reg;
        rej_next      = rej_reg;
        mem_req       = '0;
        step          = '0;
        if (accept)
        begin
            case (op)
                OP_WRITE, OP_READ:
                begin
                    if (first)
                    begin
                        if (length == '0)
                        begin
                            left_next = '0;
                            rej_next  = 1'b0;
                            step.ok   = 1'b1;
                        end
                        else
                        begin
                            left_next = length - LEN_W'(1);
                            rej_next  = (len_c > room);
                            step.ok   = (len_c <= room);
                        end
                    end
                    else if (left_reg != '0)
                    begin
                        left_next = left_reg - LEN_W'(1);
                        step.ok   = !rej_reg && (room != '0);
                    end
                    // move one byte when the item is granted
                    if (step.ok && !(first && length == '0))
                    begin
                        if (is_read)
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.addr  = rd_idx_reg;
                            rd_idx_next   = advance(rd_idx_reg, CNT_W'(1));
                            step.did_read = 1'b1;
                        end
                        else
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.addr  = wr_idx_reg;
                            mem_req.wdata = data;
                            wr_idx_next   = advance(wr_idx_reg, CNT_W'(1));
                        end
                    end
                end
                OP_SKIP:
                begin
                    if (len_c <= readable)
                    begin
                        rd_idx_next = advance(rd_idx_reg, len_c);
                        step.ok     = 1'b1;
                    end
                end
                OP_COMMIT:
                begin
                    if (len_c <= writeable)
                    begin
                        wr_idx_next = advance(wr_idx_reg, len_c);
                        step.ok     = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    step.ok     = 1'b1;
                end
                OP_STATUS:
                begin
                    step.ok = 1'b1;
                end
                default:
                begin
                    step.ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            left_reg   <= '0;
            rej_reg    <= 1'b0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            left_reg   <= left_next;
            rej_reg    <= rej_next;
        end
    end

endmodule

@@ hw/rtl/byte_ring_buffer.sv @@
// Top level of the byte ring buffer: stream ports, sequencer and result register.
`timescale 1ns / 1ps

// Byte ring buffer of 4096 cells that keeps one cell empty, so it holds up to
// 4095 bytes. Each beat on the input stream is one operation (write byte, read
// byte, skip, commit, clear, status) and yields exactly one result beat carrying
// the moved byte, an accept flag and the readable, writeable and contiguous
// counts after the operation. An item passes through ST_IDLE, which decides and
// accesses the single-port byte store, and then ST_FETCH, which collects the store's
// registered read data into the output register. The input is taken again while a result still
// waits on the output. Store contents are undefined until written; there is no
// clearing pass after reset, so the block accepts beats right away.
module byte_ring_buffer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // length[11:0], data[19:12], zero pad
    input  logic [3:0]  s_axis_tuser,   // op[2:0], first[3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // read_data, readable, writeable,
                                        // direct_readable, direct_writeable
    output logic [0:0]  m_axis_tuser    // ok[0]
);
    import brb_pkg::*;

    brb_state_t   state_reg, state_next;
    brb_mem_req_t mem_req;
    brb_step_t    step;
    brb_counts_t  counts;
    logic         accept;
    logic [BYTE_W-1:0] ram_rdata;

    logic              ok_reg, ok_next;
    logic              rd_flag_reg, rd_flag_next;
    logic              out_valid_reg, out_valid_next;
    logic              load_out;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_ok_reg;
    brb_counts_t       out_counts_reg;

    assign accept = s_axis_tvalid && s_axis_tready;

    brb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .op      (brb_op_t'(s_axis_tuser[2:0])),
        .first   (s_axis_tuser[3]),
        .length  (s_axis_tdata[11:0]),
        .data    (s_axis_tdata[19:12]),
        .mem_req (mem_req),
        .step    (step),
        .counts  (counts)
    );

    brb_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (BYTE_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        ok_next        = ok_reg;
        rd_flag_next   = rd_flag_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        load_out       = 1'b0;
        s_axis_tready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    ok_next      = step.ok;
                    rd_flag_next = step.did_read;
                    state_next   = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // hold until the output slot is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg      <= ok_next;
        rd_flag_reg <= rd_flag_next;
        if (load_out)
        begin
            out_byte_reg   <= rd_flag_reg ? ram_rdata : '0;
            out_ok_reg     <= ok_reg;
            out_counts_reg <= counts;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_counts_reg.direct_writeable,
                            out_counts_reg.direct_readable,
                            out_counts_reg.writeable,
                            out_counts_reg.readable,
                            out_byte_reg};
    assign m_axis_tuser  = out_ok_reg;

endmodule

@@ bench/byte_ring_buffer_test.sv @@
// Self-checking stream testbench for the byte ring buffer.
`timescale 1ns / 1ps

module byte_ring_buffer_test;
    import brb_pkg::*;

    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam int ITEMS       = 1100;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int CALM_AT     = 950;
    localparam int DRAIN       = 20;
    localparam longint TIMEOUT_NS = 4_000_000;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        ok;
        logic [11:0] readable;
        logic [11:0] writeable;
        logic [11:0] direct_readable;
        logic [11:0] direct_writeable;
    } ring_result_t;

    typedef struct {
        logic [2:0]   op;
        logic         first;
        logic [11:0]  len;
        logic [7:0]   data;
        bit           typed;
        ring_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // typed-in expectation that travels with the beat on the input
    bit           cur_typed = 1'b0;
    ring_result_t cur_want = '0;

    // shadow of the ring state
    logic [7:0] ring_bytes [DEPTH];
    bit         cell_filled [DEPTH];
    int         rd_idx;
    int         wr_idx;
    int         left_count;
    bit         left_rejected;

    ring_result_t pending_results [$];
    stim_row_t    directed_rows [$];
    int           beats_taken = 0;
    int           items_counted = 0;
    int           mismatches = 0;
    bit           calm = 1'b0;
    bit           hold_req = 1'b0;
    bit           hold_done = 1'b0;

    byte_ring_buffer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("byte_ring_buffer_test NOT OK");
        $finish;
    end

    function automatic int n_readable();
        if (wr_idx >= rd_idx)
            return wr_idx - rd_idx;
        return DEPTH - rd_idx + wr_idx;
    endfunction

    function automatic int n_writeable();
        int n;
        if (wr_idx >= rd_idx)
            n = DEPTH - wr_idx + rd_idx;
        else
            n = rd_idx - wr_idx;
        return (n > 0) ? n - 1 : 0;
    endfunction

    function automatic int n_direct_readable();
        if (wr_idx >= rd_idx)
            return wr_idx - rd_idx;
        return DEPTH - rd_idx;
    endfunction

    function automatic int n_direct_writeable();
        int n;
        if (wr_idx >= rd_idx)
        begin
            n = DEPTH - wr_idx;
            if (rd_idx == 0 && n > 0)
                n = n - 1;
        end
        else
        begin
            n = rd_idx - wr_idx;
            if (n > 0)
                n = n - 1;
        end
        return n;
    endfunction

    function automatic int bump(int idx, int by);
        int s;
        s = idx + by;
        if (s >= DEPTH)
            s = s - DEPTH;
        return s;
    endfunction

    function automatic bit move_one(bit is_read, logic [7:0] wbyte, output logic [7:0] rbyte);
        rbyte = 8'd0;
        if (is_read)
        begin
            if (n_readable() < 1)
                return 1'b0;
            rbyte = ring_bytes[rd_idx];
            rd_idx = bump(rd_idx, 1);
        end
        else
        begin
            if (n_writeable() < 1)
                return 1'b0;
            ring_bytes[wr_idx] = wbyte;
            cell_filled[wr_idx] = 1'b1;
            wr_idx = bump(wr_idx, 1);
        end
        return 1'b1;
    endfunction

    // Advance the shadow ring by one operation and return its result beat.
    function automatic ring_result_t apply_op(logic [2:0] op, logic first, logic [11:0] len,
                                              logic [7:0] data);
        ring_result_t res;
        logic [7:0]   rb;
        bit           is_read;
        int           room;
        res = '0;
        rb = 8'd0;
        case (op)
            OP_WRITE, OP_READ:
            begin
                is_read = (op == OP_READ);
                if (first)
                begin
                    if (len == 0)
                    begin
                        left_count = 0;
                        left_rejected = 1'b0;
                        res.ok = 1'b1;
                    end
                    else
                    begin
                        room = is_read ? n_readable() : n_writeable();
                        left_count = len - 1;
                        if (len > room)
                            left_rejected = 1'b1;
                        else
                        begin
                            left_rejected = 1'b0;
                            res.ok = move_one(is_read, data, rb);
                        end
                    end
                end
                else if (left_count != 0)
                begin
                    left_count = left_count - 1;
                    if (!left_rejected)
                        res.ok = move_one(is_read, data, rb);
                end
            end
            OP_SKIP:
                if (len <= n_readable())
                begin
                    rd_idx = bump(rd_idx, len);
                    res.ok = 1'b1;
                end
            OP_COMMIT:
                if (len <= n_writeable())
                begin
                    wr_idx = bump(wr_idx, len);
                    res.ok = 1'b1;
                end
            OP_CLEAR:
            begin
                rd_idx = 0;
                wr_idx = 0;
                res.ok = 1'b1;
            end
            OP_STATUS:
                res.ok = 1'b1;
            default:
                res.ok = 1'b0;
        endcase
        res.read_data = rb;
        res.readable = 12'(n_readable());
        res.writeable = 12'(n_writeable());
        res.direct_readable = 12'(n_direct_readable());
        res.direct_writeable = 12'(n_direct_writeable());
        return res;
    endfunction

    // True when a read beat would pull a byte out of a cell never written.
    function automatic bit read_hits_blank(logic first, logic [11:0] len);
        bit moves;
        if (first)
            moves = (len != 0) && (len <= n_readable());
        else
            moves = (left_count != 0) && !left_rejected && (n_readable() >= 1);
        return moves && !cell_filled[rd_idx];
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        ring_result_t want;
        ring_result_t got;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            got = apply_op(s_axis_tuser[2:0], s_axis_tuser[3], s_axis_tdata[11:0],
                           s_axis_tdata[19:12]);
            pending_results.push_back(cur_typed ? cur_want : got);
            beats_taken++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("read_data", want.read_data, m_axis_tdata[7:0]);
                check_field("ok", want.ok, m_axis_tuser[0]);
                check_field("readable", want.readable, m_axis_tdata[19:8]);
                check_field("writeable", want.writeable, m_axis_tdata[31:20]);
                check_field("direct_readable", want.direct_readable, m_axis_tdata[43:32]);
                check_field("direct_writeable", want.direct_writeable, m_axis_tdata[55:44]);
            end
        end
    end

    // Receiver: random stalls, one long hold-off, then always ready.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offer one beat and hold it until taken. Reads that would touch a blank cell
    // become status beats.
    task automatic offer(logic [2:0] op, logic first, logic [11:0] len, logic [7:0] data,
                         bit typed, ring_result_t want);
        logic [2:0] eff_op;
        bit         ignored;
        int         gap;
        int         target;
        eff_op = op;
        if (op == OP_READ && read_hits_blank(first, len))
            eff_op = OP_STATUS;
        ignored = (eff_op == OP_UNUSED_6) || (eff_op == OP_UNUSED_7) ||
                  ((eff_op == OP_WRITE || eff_op == OP_READ) && !first && left_count == 0);
        gap = 0;
        if (!calm && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, data, len};
        s_axis_tuser <= {first, eff_op};
        cur_typed <= typed;
        cur_want <= want;
        target = beats_taken + 1;
        do
            @(negedge clk);
        while (beats_taken < target);
        if (!ignored)
            items_counted++;
        if (items_counted >= HOLD_AT)
            hold_req = 1'b1;
        if (items_counted >= CALM_AT)
            calm = 1'b1;
    endtask

    task automatic offer_plain(logic [2:0] op, logic first, logic [11:0] len);
        offer(op, first, len, 8'($urandom), 1'b0, '0);
    endtask

    task automatic add_row(logic [2:0] op, logic first, logic [11:0] len, logic [7:0] data,
                           bit typed, logic [7:0] rd, logic ok, int r, int w, int dr, int dw);
        stim_row_t row;
        row.op = op;
        row.first = first;
        row.len = len;
        row.data = data;
        row.typed = typed;
        row.want = '{rd, ok, 12'(r), 12'(w), 12'(dr), 12'(dw)};
        directed_rows.push_back(row);
    endtask

    // Something that does not belong to the current transfer.
    task automatic side_beat();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1:    offer_plain(OP_STATUS, 1'($urandom), 12'($urandom));
            2, 3:    offer_plain(OP_SKIP, 1'($urandom), 12'($urandom_range(0, 6)));
            4, 5:    offer_plain(OP_COMMIT, 1'($urandom), 12'($urandom_range(0, 6)));
            6:       offer_plain(OP_CLEAR, 1'($urandom), 12'($urandom));
            7:       offer_plain(OP_WRITE, 1'b0, 12'($urandom));
            default: offer_plain(OP_READ, 1'b0, 12'($urandom));
        endcase
    endtask

    // A first beat carrying the length, then its continuation beats, maybe cut short.
    task automatic run_transfer(bit is_read);
        logic [2:0] op;
        int         room;
        int         len;
        int         cont;
        op = is_read ? OP_READ : OP_WRITE;
        room = is_read ? n_readable() : n_writeable();
        if ($urandom_range(0, 19) == 0)
            len = $urandom_range(0, 4095);
        else
            len = $urandom_range(1, ((room < 14) ? room : 14) + 2);
        offer_plain(op, 1'b1, 12'(len));
        cont = (len > 0) ? len - 1 : 0;
        if (cont > 24)
            cont = $urandom_range(0, 24);
        repeat (cont)
        begin
            if ($urandom_range(0, 11) == 0)
                side_beat();
            offer_plain(op, 1'b0, 12'($urandom));
        end
    endtask

    initial
    begin
        int pick;
        int k;
        rd_idx = 0;
        wr_idx = 0;
        left_count = 0;
        left_rejected = 1'b0;
        foreach (cell_filled[i])
        begin
            cell_filled[i] = 1'b0;
            ring_bytes[i] = 8'd0;
        end

        // after reset, stray items, rejects, a short transfer each way
        add_row(OP_STATUS, 1'b0, 12'd0, 8'h00, 1, 8'h00, 1, 0, 4095, 0, 4095);
        add_row(OP_WRITE, 1'b0, 12'd0, 8'h00, 1, 8'h00, 0, 0, 4095, 0, 4095);
        add_row(OP_READ, 1'b0, 12'd0, 8'h00, 1, 8'h00, 0, 0, 4095, 0, 4095);
        add_row(OP_READ, 1'b1, 12'd1, 8'h00, 1, 8'h00, 0, 0, 4095, 0, 4095);
        add_row(OP_WRITE, 1'b1, 12'd0, 8'h00, 1, 8'h00, 1, 0, 4095, 0, 4095);
        add_row(OP_WRITE, 1'b1, 12'd3, 8'hFF, 1, 8'h00, 1, 1, 4094, 1, 4094);
        add_row(OP_WRITE, 1'b0, 12'd0, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_WRITE, 1'b0, 12'd0, 8'hA5, 0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_WRITE, 1'b0, 12'd0, 8'h5A, 0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_READ, 1'b1, 12'd3, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_READ, 1'b0, 12'd0, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_READ, 1'b0, 12'd0, 8'h00, 1, 8'hA5, 1, 0, 4095, 0, 4093);
        // a new first beat abandons the open transfer and is rejected whole
        add_row(OP_WRITE, 1'b1, 12'd4095, 8'h3C, 0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_WRITE, 1'b1, 12'd4095, 8'hC3, 1, 8'h00, 0, 1, 4094, 1, 4092);
        add_row(OP_WRITE, 1'b0, 12'd0, 8'h77, 0, 8'h00, 0, 0, 0, 0, 0);
        // skip and commit past the limits, zero counts, fill to full and drain
        add_row(OP_SKIP, 1'b0, 12'd4095, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_SKIP, 1'b0, 12'd0, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_COMMIT, 1'b0, 12'd4095, 8'h00, 0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_COMMIT, 1'b1, 12'd4094, 8'h00, 1, 8'h00, 1, 4095, 0, 4093, 0);
        add_row(OP_WRITE, 1'b1, 12'd1, 8'hFF, 0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_SKIP, 1'b1, 12'd4095, 8'h00, 1, 8'h00, 1, 0, 4095, 0, 4094);
        add_row(OP_UNUSED_6, 1'b1, 12'd4095, 8'hFF, 1, 8'h00, 0, 0, 4095, 0, 4094);
        add_row(OP_UNUSED_7, 1'b0, 12'd0, 8'h00, 1, 8'h00, 0, 0, 4095, 0, 4094);
        add_row(OP_CLEAR, 1'b0, 12'd0, 8'h00, 1, 8'h00, 1, 0, 4095, 0, 4095);
        add_row(OP_STATUS, 1'b1, 12'd4095, 8'hFF, 1, 8'h00, 1, 0, 4095, 0, 4095);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].op, directed_rows[i].first, directed_rows[i].len,
                  directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

        while (items_counted < ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                run_transfer(1'b0);
            else if (pick < 74)
                run_transfer(1'b1);
            else if (pick < 80)
            begin
                // move both indices together so transfers cross the store end
                k = $urandom_range(0, n_writeable());
                offer_plain(OP_COMMIT, 1'($urandom), 12'(k));
                offer_plain(OP_SKIP, 1'($urandom), 12'(k));
            end
            else if (pick < 85)
                offer_plain(OP_SKIP, 1'($urandom),
                            ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                        : 12'($urandom_range(0, n_readable())));
            else if (pick < 89)
                offer_plain(OP_COMMIT, 1'($urandom),
                            ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                        : 12'($urandom_range(0, 8)));
            else if (pick < 91)
                offer_plain(OP_CLEAR, 1'($urandom), 12'($urandom));
            else if (pick < 95)
                offer_plain(OP_STATUS, 1'($urandom), 12'($urandom));
            else if (pick < 98)
                offer_plain(($urandom_range(0, 1) == 0) ? OP_WRITE : OP_READ, 1'b0,
                            12'($urandom));
            else
                offer_plain(($urandom_range(0, 1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7,
                            1'($urandom), 12'($urandom));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);

        if (mismatches == 0)
            $display("byte_ring_buffer_test OK");
        else
            $display("byte_ring_buffer_test NOT OK");
        $finish;
    end

endmodule
